// ===== sv/blcr_pkg.sv =====
// Package for the bond length constraint relax block.
// Holds register indexes, register widths, register reset values and the correction code type.
`default_nettype none
package blcr_pkg;

	localparam int LEN_W   = 31;
	localparam int FLOOR_W = 16;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 32;

	localparam logic [IDX_W-1:0] CFG_MIN_LEN    = 2'd0;
	localparam logic [IDX_W-1:0] CFG_MAX_LEN    = 2'd1;
	localparam logic [IDX_W-1:0] CFG_DIST_FLOOR = 2'd2;

	localparam logic [LEN_W-1:0]   MIN_LEN_RST    = 31'd65536;
	localparam logic [LEN_W-1:0]   MAX_LEN_RST    = 31'd131072;
	localparam logic [FLOOR_W-1:0] DIST_FLOOR_RST = 16'd1;

	typedef enum logic [1:0] {
		CORR_NONE = 2'd0,
		CORR_PUSH = 2'd1,
		CORR_PULL = 2'd2
	} corr_t;

endpackage
`default_nettype wire

// ===== sv/blcr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, registered stages.
// Standalone; used by bond_length_constraint_relax.
`default_nettype none
module blcr_sqrt #(
	parameter int RW = 34
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*RW-1:0] rad,
	output logic      [RW-1:0]   root,
	output logic                 rem_nz
);
	localparam int NB = 2 * RW;

	logic [RW-1:0] rt_q [RW];
	logic [RW:0]   rm_q [RW];
	logic [NB-1:0] rd_q [RW];
	logic [RW-1:0] rt_n [RW];
	logic [RW:0]   rm_n [RW];
	logic [NB-1:0] rd_n [RW];

	always_comb begin
		logic [RW-1:0] r;
		logic [RW:0]   m;
		logic [NB-1:0] d;
		logic [RW+2:0] t;
		logic [RW+2:0] tr;
		for (int k = 0; k < RW; k++) begin
			if (k == 0) begin
				r = '0;
				m = '0;
				d = rad;
			end else begin
				r = rt_q[k-1];
				m = rm_q[k-1];
				d = rd_q[k-1];
			end
			t  = {m, d[NB-1 -: 2]};
			tr = {1'b0, r, 2'b01};
			if (t >= tr) begin
				rm_n[k] = (RW+1)'(t - tr);
				rt_n[k] = {r[RW-2:0], 1'b1};
			end else begin
				rm_n[k] = t[RW:0];
				rt_n[k] = {r[RW-2:0], 1'b0};
			end
			rd_n[k] = {d[NB-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rt_q[k] <= rt_n[k];
				rm_q[k] <= rm_n[k];
				rd_q[k] <= rd_n[k];
			end
		end
	end

	assign root   = rt_q[RW-1];
	assign rem_nz = |rm_q[RW-1];

endmodule
`default_nettype wire

// ===== sv/blcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, registered stages.
// Standalone; quotient must fit QW bits. Used by bond_length_constraint_relax.
`default_nettype none
module blcr_div #(
	parameter int NW = 67,
	parameter int DW = 35,
	parameter int QW = 34
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);
	logic [DW-1:0] rm_q [QW];
	logic [QW-1:0] qo_q [QW];
	logic [QW-1:0] nl_q [QW];
	logic [DW-1:0] dn_q [QW];
	logic [DW-1:0] rm_n [QW];
	logic [QW-1:0] qo_n [QW];
	logic [QW-1:0] nl_n [QW];
	logic [DW-1:0] dn_n [QW];

	always_comb begin
		logic [DW-1:0] m;
		logic [QW-1:0] qv;
		logic [QW-1:0] nl;
		logic [DW-1:0] dn;
		logic [DW:0]   t;
		logic          ge;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				m  = DW'(num[NW-1:QW]);
				qv = '0;
				nl = num[QW-1:0];
				dn = den;
			end else begin
				m  = rm_q[k-1];
				qv = qo_q[k-1];
				nl = nl_q[k-1];
				dn = dn_q[k-1];
			end
			t  = {m, nl[QW-1]};
			ge = (t >= {1'b0, dn});
			rm_n[k] = ge ? DW'(t - {1'b0, dn}) : t[DW-1:0];
			qo_n[k] = {qv[QW-2:0], ge};
			nl_n[k] = {nl[QW-2:0], 1'b0};
			dn_n[k] = dn;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rm_q[k] <= rm_n[k];
				qo_q[k] <= qo_n[k];
				nl_q[k] <= nl_n[k];
				dn_q[k] <= dn_n[k];
			end
		end
	end

	assign quo = qo_q[QW-1];

endmodule
`default_nettype wire

// ===== sv/bond_length_constraint_relax.sv =====
// Bond length constraint relax: keeps the distance of two nodes within limits.
// Top level; uses blcr_pkg, blcr_sqrt and blcr_div.
//
// Use: the host presents both node positions (p, q) on the input channel
// (in_valid / in_stall) and takes corrected positions plus a correction code
// on the output channel (out_valid / out_stall). Registers min_len, max_len
// and dist_floor are written on the cfg channel (cfg_ready is always high);
// the host must write them only while the block is idle; no check is made.
// Throughput: one item per cycle unless stalled, no dependence between items.
// The pipeline depth is set by the bit-per-stage square root and the
// bit-per-stage dividers (three in parallel, one per axis).
// Stall: the whole pipeline holds while a result waits with out_stall high;
// the output payload stays put and in_stall follows. Bubbles stay where
// they are; the pipeline moves as one.
// Reset: clears all valid bits and loads the register reset values.
`default_nettype none
module bond_length_constraint_relax
	import blcr_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] p_x,
	input  wire logic signed [COORD_BITS-1:0] p_y,
	input  wire logic signed [COORD_BITS-1:0] p_z,
	input  wire logic signed [COORD_BITS-1:0] q_x,
	input  wire logic signed [COORD_BITS-1:0] q_y,
	input  wire logic signed [COORD_BITS-1:0] q_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed      [COORD_BITS-1:0] new_p_x,
	output logic signed      [COORD_BITS-1:0] new_p_y,
	output logic signed      [COORD_BITS-1:0] new_p_z,
	output logic signed      [COORD_BITS-1:0] new_q_x,
	output logic signed      [COORD_BITS-1:0] new_q_y,
	output logic signed      [COORD_BITS-1:0] new_q_z,
	output logic             [1:0]            correction,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic        [IDX_W-1:0]      cfg_index,
	input  wire logic        [DATA_W-1:0]     cfg_data
);
	localparam int W  = COORD_BITS;
	localparam int MW = W + 1;
	localparam int RW = W + 2;
	localparam int NB = 2 * RW;
	localparam int CW = (RW > LEN_W) ? RW : LEN_W;
	localparam int QW = CW;
	localparam int NW = MW + CW;
	localparam int DW = RW + 1;
	localparam int SW = QW + 2;

	typedef struct packed {
		logic [2:0][W-1:0]  p;
		logic [2:0][W-1:0]  q;
		logic [2:0]         sgn;
		logic [2:0][MW-1:0] mag;
	} side_t;

	typedef struct packed {
		logic [2:0][W-1:0] p;
		logic [2:0][W-1:0] q;
		logic [2:0]        sgn;
		corr_t             code;
	} tail_t;

	logic [LEN_W-1:0]   min_len_q;
	logic [LEN_W-1:0]   max_len_q;
	logic [FLOOR_W-1:0] dist_floor_q;

	logic adv;

	logic [2:0][W-1:0]    p_s1, q_s1;
	logic                 v_s1;
	side_t                sd_s2;
	logic                 v_s2;
	side_t                sd_s3;
	logic [2:0][2*MW-1:0] sq_s3;
	logic                 v_s3;
	side_t                sd_s4;
	logic [NB-1:0]        d2_s4;
	logic                 v_s4;

	side_t         sd_sq [RW];
	logic [RW-1:0] v_sq;
	logic [RW-1:0] root;
	logic          rem_nz;

	side_t         sd_s6;
	corr_t         code_s6;
	logic [CW-1:0] delta_s6;
	logic [RW-1:0] dv_s6;
	logic          v_s6;

	tail_t              tl_s7;
	logic [2:0][NW-1:0] num_s7;
	logic [DW-1:0]      den_s7;
	logic               v_s7;

	tail_t              tl_dv [QW];
	logic [QW-1:0]      v_dv;
	logic [2:0][QW-1:0] quo;

	logic [2:0][W-1:0] np_o, nq_o;
	corr_t             code_o;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q    <= MIN_LEN_RST;
			max_len_q    <= MAX_LEN_RST;
			dist_floor_q <= DIST_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_LEN:    min_len_q    <= cfg_data[LEN_W-1:0];
				CFG_MAX_LEN:    max_len_q    <= cfg_data[LEN_W-1:0];
				CFG_DIST_FLOOR: dist_floor_q <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_sq      <= '0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_dv      <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_sq      <= {v_sq[RW-2:0], v_s4};
			v_s6      <= v_sq[RW-1];
			v_s7      <= v_s6;
			v_dv      <= {v_dv[QW-2:0], v_s7};
			out_valid <= v_dv[QW-1];
		end
	end

	// front end: difference, magnitude, squares, squared length
	side_t                sd_n2;
	logic [2:0][2*MW-1:0] sq_n3;
	logic [NB-1:0]        d2_n4;

	always_comb begin
		logic signed [W:0] dr;
		for (int c = 0; c < 3; c++) begin
			dr = $signed({q_s1[c][W-1], q_s1[c]}) - $signed({p_s1[c][W-1], p_s1[c]});
			sd_n2.p[c]   = p_s1[c];
			sd_n2.q[c]   = q_s1[c];
			sd_n2.sgn[c] = dr[W];
			sd_n2.mag[c] = dr[W] ? MW'(-dr) : MW'(dr);
			sq_n3[c]     = (2*MW)'(sd_s2.mag[c]) * (2*MW)'(sd_s2.mag[c]);
		end
		d2_n4 = NB'(sq_s3[0]) + NB'(sq_s3[1]) + NB'(sq_s3[2]);
	end

	// decision on the root
	corr_t         code_n6;
	logic [CW-1:0] delta_n6;
	logic [RW-1:0] dv_n6;

	always_comb begin
		logic [CW-1:0] dz;
		logic [CW-1:0] mnz;
		logic [CW-1:0] mxz;
		logic [RW-1:0] flz;
		logic          push;
		logic          pull;
		dz   = CW'(root);
		mnz  = CW'(min_len_q);
		mxz  = CW'(max_len_q);
		flz  = (dist_floor_q == '0) ? RW'(1) : RW'(dist_floor_q);
		push = dz < mnz;
		pull = !push && ((dz > mxz) || ((dz == mxz) && rem_nz));
		if (push) begin
			code_n6  = CORR_PUSH;
			delta_n6 = mnz - dz;
			dv_n6    = (root < flz) ? flz : root;
		end else if (pull) begin
			code_n6  = CORR_PULL;
			delta_n6 = dz - mxz;
			dv_n6    = root;
		end else begin
			code_n6  = CORR_NONE;
			delta_n6 = '0;
			dv_n6    = RW'(1);
		end
	end

	function automatic logic [W-1:0] sat(input logic [SW-1:0] s);
		logic hi;
		logic lo;
		hi = !s[SW-1] && (|s[SW-2:W-1]);
		lo = s[SW-1] && !(&s[SW-2:W-1]);
		if (hi)
			sat = {1'b0, {(W-1){1'b1}}};
		else if (lo)
			sat = {1'b1, {(W-1){1'b0}}};
		else
			sat = s[W-1:0];
	endfunction

	// output: apply signed displacement and saturate
	always_comb begin
		logic signed [SW-1:0] sd;
		logic signed [SW-1:0] pe;
		logic signed [SW-1:0] qe;
		logic signed [SW-1:0] np;
		logic signed [SW-1:0] nq;
		for (int c = 0; c < 3; c++) begin
			sd = tl_dv[QW-1].sgn[c] ? -$signed(SW'(quo[c])) : $signed(SW'(quo[c]));
			pe = SW'($signed(tl_dv[QW-1].p[c]));
			qe = SW'($signed(tl_dv[QW-1].q[c]));
			if (tl_dv[QW-1].code == CORR_PUSH) begin
				np = pe - sd;
				nq = qe + sd;
			end else begin
				np = pe + sd;
				nq = qe - sd;
			end
			np_o[c] = sat(np);
			nq_o[c] = sat(nq);
		end
		code_o = tl_dv[QW-1].code;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= {p_z, p_y, p_x};
			q_s1  <= {q_z, q_y, q_x};
			sd_s2 <= sd_n2;
			sd_s3 <= sd_s2;
			sq_s3 <= sq_n3;
			sd_s4 <= sd_s3;
			d2_s4 <= d2_n4;
			sd_sq[0] <= sd_s4;
			for (int k = 1; k < RW; k++)
				sd_sq[k] <= sd_sq[k-1];
			sd_s6    <= sd_sq[RW-1];
			code_s6  <= code_n6;
			delta_s6 <= delta_n6;
			dv_s6    <= dv_n6;
			tl_s7.p    <= sd_s6.p;
			tl_s7.q    <= sd_s6.q;
			tl_s7.sgn  <= sd_s6.sgn;
			tl_s7.code <= code_s6;
			for (int c = 0; c < 3; c++)
				num_s7[c] <= NW'(sd_s6.mag[c]) * NW'(delta_s6);
			den_s7   <= {dv_s6, 1'b0};
			tl_dv[0] <= tl_s7;
			for (int k = 1; k < QW; k++)
				tl_dv[k] <= tl_dv[k-1];
			new_p_x    <= np_o[0];
			new_p_y    <= np_o[1];
			new_p_z    <= np_o[2];
			new_q_x    <= nq_o[0];
			new_q_y    <= nq_o[1];
			new_q_z    <= nq_o[2];
			correction <= code_o;
		end
	end

	blcr_sqrt #(
		.RW(RW)
	) u_sqrt (
		.clk(clk),
		.en(adv),
		.rad(d2_s4),
		.root(root),
		.rem_nz(rem_nz)
	);

	for (genvar c = 0; c < 3; c++) begin : g_div
		blcr_div #(
			.NW(NW),
			.DW(DW),
			.QW(QW)
		) u_div (
			.clk(clk),
			.en(adv),
			.num(num_s7[c]),
			.den(den_s7),
			.quo(quo[c])
		);
	end

endmodule
`default_nettype wire
